/* rtl/cds_pkg.sv */
// Package of types, codes and constants for the drive state sequencer.
`timescale 1ns / 1ps

package cds_pkg;

  localparam int unsigned AddrW = 2;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    REQ_DISABLE = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_HOME    = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    DS_NOT_READY     = 4'd0,
    DS_SW_ON_DIS     = 4'd1,
    DS_READY_SW_ON   = 4'd2,
    DS_SWITCHED_ON   = 4'd3,
    DS_OP_ENABLED    = 4'd4,
    DS_QUICK_STOP    = 4'd5,
    DS_FAULT_REACT   = 4'd6,
    DS_FAULT         = 4'd7,
    DS_UNKNOWN       = 4'd8
  } drive_state_e;

  localparam logic [3:0] RC_DONE     = 4'd0;
  localparam logic [3:0] RC_1        = 4'd1;
  localparam logic [3:0] RC_2        = 4'd2;
  localparam logic [3:0] RC_3        = 4'd3;
  localparam logic [3:0] RC_4        = 4'd4;
  localparam logic [3:0] RC_5        = 4'd5;
  localparam logic [3:0] RC_6        = 4'd6;
  localparam logic [3:0] RC_7        = 4'd7;
  localparam logic [3:0] RC_8        = 4'd8;
  localparam logic [3:0] RC_UNKNOWN  = 4'd9;
  localparam logic [3:0] RC_HOME_ERR = 4'd10;
  localparam logic [3:0] RC_HOMING   = 4'd11;

  localparam logic [15:0] MaskLo      = 16'h004F;
  localparam logic [15:0] MaskHi      = 16'h006F;
  localparam logic [15:0] MaskHome    = 16'h3400;
  localparam logic [15:0] HomeAttain  = 16'h1400;
  localparam logic [15:0] HomeErrBit  = 16'h2000;
  localparam logic [15:0] SwOpEnabled = 16'h0027;

  localparam logic [15:0] CW_ZERO     = 16'h0000;
  localparam logic [15:0] CW_SHUTDOWN = 16'h0006;
  localparam logic [15:0] CW_SW_ON    = 16'h0007;
  localparam logic [15:0] CW_ENABLE   = 16'h000F;
  localparam logic [15:0] CW_HOME_GO  = 16'h001F;
  localparam logic [15:0] CW_FLT_RST  = 16'h0080;

  localparam logic [7:0] ModeHoming = 8'h06;
  localparam logic [7:0] ModePos    = 8'h08;
  localparam logic [7:0] ModeVel    = 8'h09;
  localparam logic [7:0] ModeCur    = 8'h0A;

  localparam logic [4:0] PhaseLast  = 5'd19;
  localparam logic [4:0] PhaseHalf  = 5'd10;

  localparam logic [7:0] SettleReset = 8'd20;

  typedef struct packed {
    req_e               req_type;
    logic [15:0]        drive_status;
    logic [7:0]         mode_display;
    logic signed [31:0] actual_pos_count;
  } item_t;

  typedef struct packed {
    logic [3:0]         result_code;
    logic               write_control;
    logic [15:0]        ctrl_value;
    logic               write_home_mode;
    logic               write_target_pos;
    logic signed [31:0] target_pos_count;
    logic               write_target_vel;
    logic               write_target_cur;
  } result_t;

  function automatic drive_state_e decode_state(logic [15:0] sw);
    drive_state_e st;
    if ((sw & MaskLo) == 16'h0000)      st = DS_NOT_READY;
    else if ((sw & MaskLo) == 16'h0040) st = DS_SW_ON_DIS;
    else if ((sw & MaskHi) == 16'h0021) st = DS_READY_SW_ON;
    else if ((sw & MaskHi) == 16'h0023) st = DS_SWITCHED_ON;
    else if ((sw & MaskHi) == 16'h0027) st = DS_OP_ENABLED;
    else if ((sw & MaskHi) == 16'h0007) st = DS_QUICK_STOP;
    else if ((sw & MaskLo) == 16'h000F) st = DS_FAULT_REACT;
    else if ((sw & MaskLo) == 16'h0008) st = DS_FAULT;
    else                                st = DS_UNKNOWN;
    return st;
  endfunction

endpackage

/* rtl/cia402_drive_state_sequencer_unit.sv */
// Top level of the CiA 402 drive state sequencer.
// Takes one request beat per cycle: a beat is registered on entry, decoded and
// sequenced from the input register, and its result beat is loaded into the
// output register once that register is empty or being taken. Throughput is
// one beat per cycle whenever the output side takes results; the output
// register lets a new beat enter while a finished result waits. The settle
// count is written over APB at byte address 0 and reads back there.
`timescale 1ns / 1ps

module cia402_drive_state_sequencer_unit import cds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        drive_status_i,
  input  logic [7:0]         mode_display_i,
  input  logic signed [31:0] actual_pos_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         result_code_o,
  output logic               write_control_o,
  output logic [15:0]        ctrl_value_o,
  output logic               write_home_mode_o,
  output logic               write_target_pos_o,
  output logic signed [31:0] target_pos_count_o,
  output logic               write_target_vel_o,
  output logic               write_target_cur_o
);

  logic       in_vld_q, in_vld_d;
  item_t      item_q, item_d;
  logic       out_vld_q, out_vld_d;
  result_t    res_q, res_d;
  result_t    step_res;
  logic       adv;
  logic [7:0] settle_cycles;

  cds_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .settle_cycles_o (settle_cycles)
  );

  cds_step u_step (
    .clk_i,
    .rst_ni,
    .adv_i           (adv),
    .item_i          (item_q),
    .settle_cycles_i (settle_cycles),
    .res_o           (step_res)
  );

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_comb begin
    in_vld_d  = in_vld_q;
    item_d    = item_q;
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (adv) begin
      in_vld_d  = 1'b0;
      out_vld_d = 1'b1;
      res_d     = step_res;
    end
    if (in_valid_i && in_ready_o) begin
      in_vld_d                = 1'b1;
      item_d.req_type         = req_e'(req_type_i);
      item_d.drive_status     = drive_status_i;
      item_d.mode_display     = mode_display_i;
      item_d.actual_pos_count = actual_pos_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign out_valid_o        = out_vld_q;
  assign result_code_o      = res_q.result_code;
  assign write_control_o    = res_q.write_control;
  assign ctrl_value_o       = res_q.ctrl_value;
  assign write_home_mode_o  = res_q.write_home_mode;
  assign write_target_pos_o = res_q.write_target_pos;
  assign target_pos_count_o = res_q.target_pos_count;
  assign write_target_vel_o = res_q.write_target_vel;
  assign write_target_cur_o = res_q.write_target_cur;

endmodule

/* rtl/cds_cfg_regs.sv */
// APB configuration register holding the settle count.
`timescale 1ns / 1ps

module cds_cfg_regs import cds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic [7:0]       settle_cycles_o
);

  logic [7:0] settle_q, settle_d;
  logic       wr_en;

  assign wr_en  = psel && penable && pwrite && pready && (paddr == '0);
  assign pready = 1'b1;

  always_comb begin
    settle_d = settle_q;
    if (wr_en) begin
      settle_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleReset;
    end else begin
      settle_q <= settle_d;
    end
  end

  assign prdata          = {{(DataW-8){1'b0}}, settle_q};
  assign settle_cycles_o = settle_q;

endmodule

/* rtl/cds_step.sv */
// Drive state decode, control word selection and sequencing state.
`timescale 1ns / 1ps

module cds_step import cds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  item_t      item_i,
  input  logic [7:0] settle_cycles_i,
  output result_t    res_o
);

  logic [7:0]   settle_left_q, settle_left_d;
  logic [4:0]   home_phase_q, home_phase_d;
  logic         clear_pending_q, clear_pending_d;
  drive_state_e st;
  logic [7:0]   settle_dec;
  logic [4:0]   phase_inc;
  logic [15:0]  home_bits;

  assign st         = decode_state(item_i.drive_status);
  assign settle_dec = (settle_left_q != 8'd0) ? settle_left_q - 8'd1 : 8'd0;
  assign phase_inc  = (home_phase_q >= PhaseLast) ? 5'd0 : home_phase_q + 5'd1;
  assign home_bits  = item_i.drive_status & MaskHome;

  always_comb begin
    res_o           = '0;
    res_o.result_code = RC_UNKNOWN;
    settle_left_d   = settle_left_q;
    home_phase_d    = home_phase_q;
    clear_pending_d = clear_pending_q;
    case (item_i.req_type)
      REQ_DISABLE: begin
        res_o.write_control = (st != DS_UNKNOWN);
        res_o.ctrl_value    = (st == DS_FAULT) ? CW_FLT_RST : CW_ZERO;
        case (st)
          DS_NOT_READY:   res_o.result_code = RC_1;
          DS_SW_ON_DIS:   res_o.result_code = RC_DONE;
          DS_READY_SW_ON: res_o.result_code = RC_2;
          DS_SWITCHED_ON: res_o.result_code = RC_3;
          DS_OP_ENABLED:  res_o.result_code = RC_4;
          DS_QUICK_STOP:  res_o.result_code = RC_5;
          DS_FAULT_REACT: res_o.result_code = RC_6;
          DS_FAULT:       res_o.result_code = RC_7;
          default:        res_o.result_code = RC_UNKNOWN;
        endcase
      end
      REQ_ENABLE: begin
        case (st)
          DS_NOT_READY: res_o.result_code = RC_1;
          DS_SW_ON_DIS: begin
            res_o.write_control = 1'b1;
            res_o.ctrl_value    = CW_SHUTDOWN;
            res_o.result_code   = RC_2;
          end
          DS_READY_SW_ON: begin
            res_o.write_control = 1'b1;
            res_o.ctrl_value    = CW_SW_ON;
            res_o.result_code   = RC_3;
          end
          DS_SWITCHED_ON: begin
            res_o.write_control = 1'b1;
            res_o.ctrl_value    = CW_ENABLE;
            res_o.result_code   = RC_4;
            settle_left_d       = settle_cycles_i;
            if (item_i.mode_display == ModePos) begin
              res_o.write_target_pos = 1'b1;
            end else if (item_i.mode_display == ModeVel) begin
              res_o.write_target_vel = 1'b1;
            end else if (item_i.mode_display == ModeCur) begin
              res_o.write_target_cur = 1'b1;
            end else begin
              res_o.write_target_pos = 1'b1;
              res_o.write_target_vel = 1'b1;
              res_o.write_target_cur = 1'b1;
            end
            if (res_o.write_target_pos) begin
              res_o.target_pos_count = item_i.actual_pos_count;
            end
          end
          DS_OP_ENABLED: begin
            settle_left_d     = settle_dec;
            res_o.result_code = (settle_dec != 8'd0) ? RC_5 : RC_DONE;
          end
          DS_QUICK_STOP, DS_FAULT_REACT: begin
            res_o.write_control = 1'b1;
            res_o.ctrl_value    = CW_ZERO;
            res_o.result_code   = (st == DS_QUICK_STOP) ? RC_6 : RC_7;
          end
          DS_FAULT: begin
            res_o.write_control = 1'b1;
            res_o.ctrl_value    = CW_FLT_RST;
            res_o.result_code   = RC_8;
          end
          default: res_o.result_code = RC_UNKNOWN;
        endcase
      end
      REQ_HOME: begin
        if (clear_pending_q &&
            ((item_i.drive_status & MaskHi) != SwOpEnabled)) begin
          home_phase_d      = 5'd0;
          clear_pending_d   = 1'b1;
          res_o.result_code = RC_UNKNOWN;
        end else if (item_i.mode_display != ModeHoming) begin
          res_o.write_home_mode = 1'b1;
          res_o.result_code     = RC_2;
        end else if (clear_pending_q) begin
          res_o.write_control = 1'b1;
          res_o.result_code   = RC_3;
          if (home_bits != 16'h0000) begin
            home_phase_d     = phase_inc;
            res_o.ctrl_value = (phase_inc < PhaseHalf) ? CW_HOME_GO : CW_ENABLE;
          end else begin
            res_o.ctrl_value = CW_ENABLE;
            clear_pending_d  = 1'b0;
          end
        end else if (home_bits == 16'h0000) begin
          res_o.write_control = 1'b1;
          res_o.ctrl_value    = CW_HOME_GO;
          res_o.result_code   = RC_4;
        end else if (home_bits == HomeAttain) begin
          res_o.write_control = 1'b1;
          res_o.ctrl_value    = CW_ENABLE;
          home_phase_d        = 5'd0;
          clear_pending_d     = 1'b1;
          res_o.result_code   = RC_DONE;
        end else if ((item_i.drive_status & HomeErrBit) != 16'h0000) begin
          home_phase_d      = 5'd0;
          clear_pending_d   = 1'b1;
          res_o.result_code = RC_HOME_ERR;
        end else begin
          res_o.result_code = RC_HOMING;
        end
      end
      default: res_o.result_code = RC_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_left_q   <= 8'd0;
      home_phase_q    <= 5'd0;
      clear_pending_q <= 1'b1;
    end else if (adv_i) begin
      settle_left_q   <= settle_left_d;
      home_phase_q    <= home_phase_d;
      clear_pending_q <= clear_pending_d;
    end
  end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the CiA 402 drive state sequencer unit.
`timescale 1ns / 1ps

module testbench;
  import cds_pkg::*;

  localparam int unsigned RegSettleIdx = 0;
  localparam logic [AddrW-1:0] SettleAddr = AddrW'(4 * RegSettleIdx);
  localparam int unsigned RandomBeats = 510;
  localparam int unsigned ChunkBeats = 60;
  localparam int unsigned CycleLimit = 200000;

  localparam logic [15:0] PatNotReady   = 16'h0000;
  localparam logic [15:0] PatSwOnDis    = 16'h0040;
  localparam logic [15:0] PatReady      = 16'h0021;
  localparam logic [15:0] PatSwitchedOn = 16'h0023;
  localparam logic [15:0] PatQuickStop  = 16'h0007;
  localparam logic [15:0] PatFltReact   = 16'h000F;
  localparam logic [15:0] PatFault      = 16'h0008;

  localparam logic [2:0] HbNone   = 3'd0;
  localparam logic [2:0] HbBusyA  = 3'd1;
  localparam logic [2:0] HbBusyB  = 3'd2;
  localparam logic [2:0] HbAttain = 3'd3;
  localparam logic [2:0] HbErrLo  = 3'd4;
  localparam logic [2:0] HbErrHi  = 3'd7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         req_type_i = '0;
  logic [15:0]        drive_status_i = '0;
  logic [7:0]         mode_display_i = '0;
  logic signed [31:0] actual_pos_count_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [3:0]         result_code_o;
  logic               write_control_o;
  logic [15:0]        ctrl_value_o;
  logic               write_home_mode_o;
  logic               write_target_pos_o;
  logic signed [31:0] target_pos_count_o;
  logic               write_target_vel_o;
  logic               write_target_cur_o;

  logic [7:0]  settle_reload = SettleReset;
  logic [7:0]  settle_count = '0;
  logic [4:0]  toggle_phase = '0;
  logic        flags_stale = 1'b1;

  result_t     drive_cmd_q[$];
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned ready_hold = 0;
  bit          steady_flow = 1'b0;

  always #4 clk_i = ~clk_i;

  cia402_drive_state_sequencer_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .drive_status_i     (drive_status_i),
    .mode_display_i     (mode_display_i),
    .actual_pos_count_i (actual_pos_count_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_code_o      (result_code_o),
    .write_control_o    (write_control_o),
    .ctrl_value_o       (ctrl_value_o),
    .write_home_mode_o  (write_home_mode_o),
    .write_target_pos_o (write_target_pos_o),
    .target_pos_count_o (target_pos_count_o),
    .write_target_vel_o (write_target_vel_o),
    .write_target_cur_o (write_target_cur_o)
  );

  function automatic drive_state_e classify_status(logic [15:0] sw);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = sw & MaskLo;
    hi = sw & MaskHi;
    if (lo == PatNotReady) return DS_NOT_READY;
    if (lo == PatSwOnDis) return DS_SW_ON_DIS;
    if (hi == PatReady) return DS_READY_SW_ON;
    if (hi == PatSwitchedOn) return DS_SWITCHED_ON;
    if (hi == SwOpEnabled) return DS_OP_ENABLED;
    if (hi == PatQuickStop) return DS_QUICK_STOP;
    if (lo == PatFltReact) return DS_FAULT_REACT;
    if (lo == PatFault) return DS_FAULT;
    return DS_UNKNOWN;
  endfunction

  function automatic result_t next_drive_command(item_t it);
    result_t      cmd;
    drive_state_e st;
    logic [15:0]  hb;
    cmd = '0;
    cmd.result_code = RC_UNKNOWN;
    st = classify_status(it.drive_status);
    hb = it.drive_status & MaskHome;
    case (it.req_type)
      REQ_DISABLE: begin
        if (st != DS_UNKNOWN) begin
          cmd.write_control = 1'b1;
          cmd.ctrl_value = (st == DS_FAULT) ? CW_FLT_RST : CW_ZERO;
        end
        case (st)
          DS_NOT_READY:   cmd.result_code = RC_1;
          DS_SW_ON_DIS:   cmd.result_code = RC_DONE;
          DS_READY_SW_ON: cmd.result_code = RC_2;
          DS_SWITCHED_ON: cmd.result_code = RC_3;
          DS_OP_ENABLED:  cmd.result_code = RC_4;
          DS_QUICK_STOP:  cmd.result_code = RC_5;
          DS_FAULT_REACT: cmd.result_code = RC_6;
          DS_FAULT:       cmd.result_code = RC_7;
          default: ;
        endcase
      end
      REQ_ENABLE: begin
        case (st)
          DS_NOT_READY: cmd.result_code = RC_1;
          DS_SW_ON_DIS: begin
            cmd.write_control = 1'b1;
            cmd.ctrl_value = CW_SHUTDOWN;
            cmd.result_code = RC_2;
          end
          DS_READY_SW_ON: begin
            cmd.write_control = 1'b1;
            cmd.ctrl_value = CW_SW_ON;
            cmd.result_code = RC_3;
          end
          DS_SWITCHED_ON: begin
            cmd.write_control = 1'b1;
            cmd.ctrl_value = CW_ENABLE;
            settle_count = settle_reload;
            case (it.mode_display)
              ModePos: cmd.write_target_pos = 1'b1;
              ModeVel: cmd.write_target_vel = 1'b1;
              ModeCur: cmd.write_target_cur = 1'b1;
              default: begin
                cmd.write_target_pos = 1'b1;
                cmd.write_target_vel = 1'b1;
                cmd.write_target_cur = 1'b1;
              end
            endcase
            if (cmd.write_target_pos) cmd.target_pos_count = it.actual_pos_count;
            cmd.result_code = RC_4;
          end
          DS_OP_ENABLED: begin
            if (settle_count != 0) settle_count = settle_count - 8'd1;
            cmd.result_code = (settle_count != 0) ? RC_5 : RC_DONE;
          end
          DS_QUICK_STOP: begin
            cmd.write_control = 1'b1;
            cmd.ctrl_value = CW_ZERO;
            cmd.result_code = RC_6;
          end
          DS_FAULT_REACT: begin
            cmd.write_control = 1'b1;
            cmd.ctrl_value = CW_ZERO;
            cmd.result_code = RC_7;
          end
          DS_FAULT: begin
            cmd.write_control = 1'b1;
            cmd.ctrl_value = CW_FLT_RST;
            cmd.result_code = RC_8;
          end
          default: ;
        endcase
      end
      REQ_HOME: begin
        if (flags_stale && (it.drive_status & MaskHi) != SwOpEnabled) begin
          toggle_phase = '0;
          flags_stale = 1'b1;
        end else if (it.mode_display != ModeHoming) begin
          cmd.write_home_mode = 1'b1;
          cmd.result_code = RC_2;
        end else if (flags_stale) begin
          cmd.write_control = 1'b1;
          if (hb != 16'h0000) begin
            toggle_phase = (toggle_phase >= PhaseLast) ? 5'd0 : toggle_phase + 5'd1;
            cmd.ctrl_value = (toggle_phase < PhaseHalf) ? CW_HOME_GO : CW_ENABLE;
          end else begin
            cmd.ctrl_value = CW_ENABLE;
            flags_stale = 1'b0;
          end
          cmd.result_code = RC_3;
        end else if (hb == 16'h0000) begin
          cmd.write_control = 1'b1;
          cmd.ctrl_value = CW_HOME_GO;
          cmd.result_code = RC_4;
        end else if (hb == HomeAttain) begin
          cmd.write_control = 1'b1;
          cmd.ctrl_value = CW_ENABLE;
          toggle_phase = '0;
          flags_stale = 1'b1;
          cmd.result_code = RC_DONE;
        end else if ((it.drive_status & HomeErrBit) != 16'h0000) begin
          toggle_phase = '0;
          flags_stale = 1'b1;
          cmd.result_code = RC_HOME_ERR;
        end else begin
          cmd.result_code = RC_HOMING;
        end
      end
      default: ;
    endcase
    return cmd;
  endfunction

  function automatic int unsigned draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic signed [31:0] rand_pos();
    return $urandom();
  endfunction

  function automatic logic [7:0] pick_mode();
    case ($urandom_range(0, 4))
      0: return ModePos;
      1: return ModeVel;
      2: return ModeCur;
      3: return ModeHoming;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic drive_state_e rand_state();
    return drive_state_e'($urandom_range(0, 8));
  endfunction

  function automatic logic [15:0] make_status(drive_state_e st);
    logic [15:0] sw;
    sw = 16'($urandom());
    case (st)
      DS_NOT_READY:   sw = (sw & ~MaskLo) | PatNotReady;
      DS_SW_ON_DIS:   sw = (sw & ~MaskLo) | PatSwOnDis;
      DS_READY_SW_ON: sw = (sw & ~MaskHi) | PatReady;
      DS_SWITCHED_ON: sw = (sw & ~MaskHi) | PatSwitchedOn;
      DS_OP_ENABLED:  sw = (sw & ~MaskHi) | SwOpEnabled;
      DS_QUICK_STOP:  sw = (sw & ~MaskHi) | PatQuickStop;
      DS_FAULT_REACT: sw = (sw & ~MaskLo) | PatFltReact;
      DS_FAULT:       sw = (sw & ~MaskLo) | PatFault;
      default: begin
        while (classify_status(sw) != DS_UNKNOWN) sw = 16'($urandom());
      end
    endcase
    return sw;
  endfunction

  function automatic logic [15:0] home_bits(logic [2:0] k);
    logic [15:0] hb;
    hb = '0;
    hb[10] = k[0];
    hb[12] = k[1];
    hb[13] = k[2];
    return hb;
  endfunction

  function automatic logic [15:0] homing_status(logic [2:0] k);
    return (make_status(DS_OP_ENABLED) & ~MaskHome) | home_bits(k);
  endfunction

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      fail_cnt++;
    end
  endtask

  task automatic send_beat(input req_e rq, input logic [15:0] sw, input logic [7:0] md,
                           input logic signed [31:0] pos);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rq;
    drive_status_i <= sw;
    mode_display_i <= md;
    actual_pos_count_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (results_seen != beats_sent) @(posedge clk_i);
  endtask

  task automatic check_settle_readback(input logic [7:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= SettleAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    compare_field("settle_cycles readback", DataW'(want), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_settle(input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SettleAddr;
    pwdata <= DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    settle_reload = val;
    check_settle_readback(val);
  endtask

  task automatic home_beat(input logic [2:0] k);
    logic [15:0] sw;
    logic [7:0]  md;
    sw = homing_status(k);
    if ($urandom_range(0, 15) == 0) sw = make_status(rand_state());
    md = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : ModeHoming;
    send_beat(REQ_HOME, sw, md, rand_pos());
  endtask

  task automatic test_register_default();
    check_settle_readback(SettleReset);
  endtask

  task automatic test_disable_states();
    int s;
    for (s = 0; s <= int'(DS_UNKNOWN); s++) begin
      send_beat(REQ_DISABLE, make_status(drive_state_e'(s)), pick_mode(), rand_pos());
    end
    wait_quiet();
  endtask

  task automatic test_enable_states();
    send_beat(REQ_ENABLE, make_status(DS_NOT_READY), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_SW_ON_DIS), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_READY_SW_ON), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_SWITCHED_ON), ModePos, 32'sh8000_0000);
    send_beat(REQ_ENABLE, make_status(DS_OP_ENABLED), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_QUICK_STOP), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_FAULT_REACT), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_FAULT), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_UNKNOWN), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_SWITCHED_ON), ModeVel, rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_SWITCHED_ON), ModeCur, rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_SWITCHED_ON), 8'hFF, 32'sh7FFF_FFFF);
    send_beat(REQ_UNUSED, 16'hFFFF, 8'hFF, rand_pos());
    wait_quiet();
  endtask

  task automatic test_settle_extremes();
    program_settle(8'hFF);
    send_beat(REQ_ENABLE, make_status(DS_SWITCHED_ON), ModeHoming, rand_pos());
    repeat (3) send_beat(REQ_ENABLE, make_status(DS_OP_ENABLED), pick_mode(), rand_pos());
    wait_quiet();
    program_settle(8'h00);
    send_beat(REQ_ENABLE, make_status(DS_SWITCHED_ON), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_OP_ENABLED), pick_mode(), rand_pos());
    wait_quiet();
    program_settle(8'h02);
    send_beat(REQ_ENABLE, make_status(DS_SWITCHED_ON), pick_mode(), rand_pos());
    repeat (3) send_beat(REQ_ENABLE, make_status(DS_OP_ENABLED), pick_mode(), rand_pos());
    wait_quiet();
  endtask

  task automatic test_homing_directed();
    send_beat(REQ_HOME, make_status(DS_SWITCHED_ON), ModeHoming, rand_pos());
    send_beat(REQ_HOME, homing_status(HbNone), ModePos, rand_pos());
    send_beat(REQ_HOME, homing_status(HbErrHi), ModeHoming, rand_pos());
    send_beat(REQ_HOME, homing_status(HbBusyA), ModeHoming, rand_pos());
    send_beat(REQ_HOME, homing_status(HbNone), ModeHoming, rand_pos());
    send_beat(REQ_HOME, homing_status(HbNone), ModeHoming, rand_pos());
    send_beat(REQ_HOME, homing_status(HbBusyB), ModeHoming, rand_pos());
    send_beat(REQ_HOME, homing_status(HbAttain), ModeHoming, rand_pos());
    send_beat(REQ_HOME, homing_status(HbNone), ModeHoming, rand_pos());
    send_beat(REQ_HOME, homing_status(HbNone), ModeVel, rand_pos());
    send_beat(REQ_HOME, homing_status(3'd5), ModeHoming, rand_pos());
    wait_quiet();
  endtask

  task automatic run_enable_walk();
    send_beat(REQ_ENABLE, make_status(rand_state()), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_SW_ON_DIS), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_READY_SW_ON), pick_mode(), rand_pos());
    send_beat(REQ_ENABLE, make_status(DS_SWITCHED_ON), pick_mode(), rand_pos());
    repeat ($urandom_range(1, 12)) begin
      send_beat(REQ_ENABLE, make_status(DS_OP_ENABLED), pick_mode(), rand_pos());
    end
  endtask

  task automatic run_home_sequence();
    repeat ($urandom_range(0, 26)) home_beat(3'($urandom_range(1, 7)));
    home_beat(HbNone);
    repeat ($urandom_range(0, 2)) home_beat(HbNone);
    repeat ($urandom_range(0, 3)) home_beat(3'($urandom_range(HbBusyA, HbBusyB)));
    if ($urandom_range(0, 1) == 0) home_beat(HbAttain);
    else home_beat(3'($urandom_range(HbErrLo, HbErrHi)));
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned chunk_end;
    logic [7:0]  val;
    stop_at = beats_sent + RandomBeats;
    while (beats_sent < stop_at) begin
      case ($urandom_range(0, 5))
        0: val = 8'hFF;
        1: val = 8'($urandom());
        default: val = 8'($urandom_range(0, 6));
      endcase
      program_settle(val);
      steady_flow = ($urandom_range(0, 3) == 0);
      chunk_end = beats_sent + ChunkBeats;
      while (beats_sent < chunk_end && beats_sent < stop_at) begin
        case ($urandom_range(0, 9))
          0, 1, 2: run_enable_walk();
          3, 4, 5: run_home_sequence();
          6, 7: begin
            repeat ($urandom_range(1, 6)) begin
              send_beat(REQ_DISABLE, make_status(rand_state()), pick_mode(), rand_pos());
            end
          end
          default: begin
            repeat ($urandom_range(1, 4)) begin
              send_beat(req_e'($urandom_range(0, 3)), 16'($urandom()), 8'($urandom()),
                        rand_pos());
            end
          end
        endcase
      end
      wait_quiet();
    end
    steady_flow = 1'b0;
  endtask

  always @(posedge clk_i) begin : result_check
    item_t   beat_in;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (drive_cmd_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_cnt++;
        end else begin
          want = drive_cmd_q.pop_front();
          compare_field("result_code", 32'(want.result_code), 32'(result_code_o));
          compare_field("write_control", 32'(want.write_control), 32'(write_control_o));
          compare_field("ctrl_value", 32'(want.ctrl_value), 32'(ctrl_value_o));
          compare_field("write_home_mode", 32'(want.write_home_mode),
                        32'(write_home_mode_o));
          compare_field("write_target_pos", 32'(want.write_target_pos),
                        32'(write_target_pos_o));
          compare_field("target_pos_count", want.target_pos_count, target_pos_count_o);
          compare_field("write_target_vel", 32'(want.write_target_vel),
                        32'(write_target_vel_o));
          compare_field("write_target_cur", 32'(want.write_target_cur),
                        32'(write_target_cur_o));
        end
        ready_hold = draw_gap();
      end
      if (in_valid_i && in_ready_o) begin
        beat_in.req_type = req_e'(req_type_i);
        beat_in.drive_status = drive_status_i;
        beat_in.mode_display = mode_display_i;
        beat_in.actual_pos_count = actual_pos_count_i;
        drive_cmd_q.push_back(next_drive_command(beat_in));
      end
      if (ready_hold != 0) begin
        ready_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("cia402_drive_state_sequencer_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_default();
    test_disable_states();
    test_enable_states();
    test_settle_extremes();
    test_homing_directed();
    test_random_traffic();
    repeat (8) @(posedge clk_i);
    if (drive_cmd_q.size() != 0) begin
      $error("%0d expected result beats never arrived", drive_cmd_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("cia402_drive_state_sequencer_unit verification clean");
    end else begin
      $display("cia402_drive_state_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cds_pkg.sv
rtl/cds_cfg_regs.sv
rtl/cds_step.sv
rtl/cia402_drive_state_sequencer_unit.sv
dv/testbench.sv
